FILE: rtl/mtbs_pkg.sv
// Shared types, constants and helpers for the mip texel store and bilinear sampler.
// Used by mtbs_ctrl, mtbs_dpath and the top level.
package mtbs_pkg;

   localparam int MAX_DIM_LOG2 = 8;
   localparam int MAX_LEVELS   = 9;
   localparam int WEIGHT_BITS  = 8;
   localparam int MAX_DIM      = 1 << MAX_DIM_LOG2;
   localparam int DIM_W        = MAX_DIM_LOG2 + 1;
   localparam int IDX_W        = MAX_DIM_LOG2;
   localparam int TEX_DEPTH    = ((1 << (2 * (MAX_DIM_LOG2 + 1))) - 1) / 3;
   localparam int ADDR_W       = $clog2(TEX_DEPTH);
   localparam int LVL_W        = $clog2(MAX_LEVELS);
   localparam int WGT_W        = 2 * WEIGHT_BITS + 1;
   localparam int ACC_W        = WGT_W + 8;
   localparam int ROUND_SH     = 2 * WEIGHT_BITS - 8;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] REG_BASE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_BASE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_LEVEL_COUNT  = 2'd2;
   localparam logic [1:0] REG_TEXEL_FORMAT = 2'd3;

   localparam logic [1:0] FMT_R8     = 2'd0;
   localparam logic [1:0] FMT_RG88   = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_ACCESS, ST_FETCH, ST_DRAIN, ST_FINISH
   } state_type;

   typedef struct packed {
      logic       clear_init;
      logic       clear_step;
      logic       capture;
      logic       setup;
      logic       access;
      logic       fetch;
      logic [1:0] corner;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic       bad;
      logic [1:0] op;
      logic       out_busy;
   } stat_type;

   typedef struct packed {
      logic [IDX_W-1:0]       i0;
      logic [IDX_W-1:0]       i1;
      logic [WEIGHT_BITS-1:0] frac;
   } axis_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

   function automatic logic [3:0] clamp_levels(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == '0) r = 4'd1;
      else if (v > 4'(MAX_LEVELS)) r = 4'(MAX_LEVELS);
      return r;
   endfunction

   // sample point coord*size - 0.5, biased by one texel to stay non-negative
   function automatic axis_type axis_setup(input logic [15:0] coord,
                                           input logic [DIM_W-1:0] size);
      logic [DIM_W+16:0]  q;
      logic [DIM_W:0]     top;
      axis_type           r;
      q      = (DIM_W+17)'(coord) * (DIM_W+17)'(size) + (DIM_W+17)'(32768);
      top    = q[DIM_W+16:16];
      r.frac = q[15:16-WEIGHT_BITS];
      r.i0   = (top == '0) ? IDX_W'(size - DIM_W'(1)) : IDX_W'(top - (DIM_W+1)'(1));
      r.i1   = (top >= (DIM_W+1)'(size)) ? '0 : IDX_W'(top);
      return r;
   endfunction

endpackage

FILE: rtl/mtbs_ctrl.sv
// Controller state machine: clearing pass, item sequencing, corner fetch order.
// Depends on mtbs_pkg; drives mtbs_dpath through cmd_type, watches stat_type.
module mtbs_ctrl
   import mtbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     csr_fire,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     req_ready,
   output logic     csr_ready
);

   state_type  state_ff, state_in;
   logic [1:0] corner_ff, corner_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      corner_in  = corner_ff;
      cmd        = '0;
      cmd.corner = corner_ff;
      req_ready  = 1'b0;
      csr_ready  = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = !csr_fire;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (stat.bad) state_in = ST_FINISH;
            else if (stat.op == OP_SAMPLE) begin
               state_in  = ST_FETCH;
               corner_in = '0;
            end else state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            if (corner_ff == 2'd3) state_in = ST_DRAIN;
            else corner_in = corner_ff + 2'd1;
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_fire) begin
         cmd            = '0;
         cmd.clear_init = 1'b1;
         state_in       = ST_CLEAR;
      end
   end

   a_csr_restarts_clear: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> state_ff == ST_CLEAR)
      else $error("register write did not restart clearing");

   a_drain_after_last_corner: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> $past(state_ff) == ST_FETCH && $past(corner_ff) == 2'd3)
      else $error("drain without four corner fetches");

   a_finish_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !stat.out_busy)
      else $error("result loaded over a waiting word");

endmodule

FILE: rtl/mtbs_dpath.sv
// Datapath: config registers, level layout, texel memory, sampler arithmetic, result register.
// Depends on mtbs_pkg; sequenced by mtbs_ctrl through cmd_type.
module mtbs_dpath
   import mtbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  operation,
   input  logic [3:0]  level,
   input  logic [7:0]  texel_x,
   input  logic [7:0]  texel_y,
   input  logic [7:0]  red_in,
   input  logic [7:0]  green_in,
   input  logic [7:0]  blue_in,
   input  logic [15:0] coord_u,
   input  logic [15:0] coord_v,
   input  logic        csr_fire,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [15:0] red_out,
   output logic [15:0] green_out,
   output logic [15:0] blue_out,
   output logic        status
);

   logic [DIM_W-1:0] bw_ff, bh_ff;
   logic [3:0]       lc_ff;
   logic [1:0]       fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= DIM_W'(MAX_DIM);
         bh_ff  <= DIM_W'(MAX_DIM);
         lc_ff  <= 4'd1;
         fmt_ff <= FMT_RGB888;
      end else if (csr_fire) begin
         case (csr_index)
            REG_BASE_WIDTH:   bw_ff  <= csr_data;
            REG_BASE_HEIGHT:  bh_ff  <= csr_data;
            REG_LEVEL_COUNT:  lc_ff  <= csr_data[3:0];
            REG_TEXEL_FORMAT: fmt_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] bw_c, bh_c;
   logic [3:0]       lc_c;
   logic [2:0]       lane_en;
   assign bw_c    = clamp_dim(bw_ff);
   assign bh_c    = clamp_dim(bh_ff);
   assign lc_c    = clamp_levels(lc_ff);
   assign lane_en = {fmt_ff != FMT_R8 && fmt_ff != FMT_RG88, fmt_ff != FMT_R8, 1'b1};

   // clearing pass, which also builds the level layout in its first cycles
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] run_off_ff;
   logic [ADDR_W-1:0] off_ff [MAX_LEVELS];
   logic [DIM_W-1:0]  lw_ff  [MAX_LEVELS];
   logic [DIM_W-1:0]  lh_ff  [MAX_LEVELS];
   logic [LVL_W-1:0]  step_k;
   logic [DIM_W-1:0]  step_w, step_h;
   logic [2*DIM_W-1:0] step_area;

   assign step_k    = clr_cnt_ff[LVL_W-1:0];
   assign step_w    = ((bw_c >> step_k) == '0) ? DIM_W'(1) : (bw_c >> step_k);
   assign step_h    = ((bh_c >> step_k) == '0) ? DIM_W'(1) : (bh_c >> step_k);
   assign step_area = (2*DIM_W)'(step_w) * (2*DIM_W)'(step_h);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_init) begin
         clr_cnt_ff <= '0;
         run_off_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (clr_cnt_ff < ADDR_W'(MAX_LEVELS)) begin
            off_ff[step_k] <= run_off_ff;
            lw_ff[step_k]  <= step_w;
            lh_ff[step_k]  <= step_h;
            run_off_ff     <= run_off_ff + ADDR_W'(step_area);
         end
      end
   end

   assign stat.clear_last = clr_cnt_ff == ADDR_W'(TEX_DEPTH - 1);

   // captured word
   logic [1:0]  op_ff;
   logic [3:0]  lvl_ff;
   logic [7:0]  tx_ff, ty_ff, r_ff, g_ff, b_ff;
   logic [15:0] u_ff, v_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= operation;
         lvl_ff <= level;
         tx_ff  <= texel_x;
         ty_ff  <= texel_y;
         r_ff   <= red_in;
         g_ff   <= green_in;
         b_ff   <= blue_in;
         u_ff   <= coord_u;
         v_ff   <= coord_v;
      end
   end

   logic             lvl_ok;
   logic [LVL_W-1:0] lvl_sel;
   logic [DIM_W-1:0] cur_w, cur_h;
   logic             bad;
   axis_type         ax_u, ax_v;

   assign lvl_ok  = lvl_ff < lc_c;
   assign lvl_sel = lvl_ok ? LVL_W'(lvl_ff) : '0;
   assign cur_w   = lw_ff[lvl_sel];
   assign cur_h   = lh_ff[lvl_sel];
   assign bad     = op_ff == OP_NONE || !lvl_ok ||
                    (op_ff != OP_SAMPLE &&
                     (DIM_W'(tx_ff) >= cur_w || DIM_W'(ty_ff) >= cur_h));
   assign ax_u    = axis_setup(u_ff, cur_w);
   assign ax_v    = axis_setup(v_ff, cur_h);
   assign stat.bad = bad;
   assign stat.op  = op_ff;

   logic              bad_ff;
   logic [DIM_W-1:0]  w_s_ff;
   logic [ADDR_W-1:0] off_s_ff, addr_ff;
   axis_type          au_ff, av_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         bad_ff   <= bad;
         w_s_ff   <= cur_w;
         off_s_ff <= off_ff[lvl_sel];
         addr_ff  <= ADDR_W'(off_ff[lvl_sel] + ADDR_W'(ty_ff) * ADDR_W'(cur_w)
                             + ADDR_W'(tx_ff));
         au_ff    <= ax_u;
         av_ff    <= ax_v;
      end
   end

   // corner address and weight
   logic [IDX_W-1:0]       cx, cy;
   logic [ADDR_W-1:0]      corner_addr;
   logic [WEIGHT_BITS:0]   wu, wv;

   assign cx = cmd.corner[0] ? au_ff.i1 : au_ff.i0;
   assign cy = cmd.corner[1] ? av_ff.i1 : av_ff.i0;
   assign corner_addr = ADDR_W'(off_s_ff + ADDR_W'(cy) * ADDR_W'(w_s_ff) + ADDR_W'(cx));
   assign wu = cmd.corner[0] ? (WEIGHT_BITS+1)'(au_ff.frac)
                             : (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - (WEIGHT_BITS+1)'(au_ff.frac);
   assign wv = cmd.corner[1] ? (WEIGHT_BITS+1)'(av_ff.frac)
                             : (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - (WEIGHT_BITS+1)'(av_ff.frac);

   // single-port texel memory with byte lanes
   logic [23:0]       mem [TEX_DEPTH];
   logic [23:0]       rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [23:0]       mem_wdata;
   logic [2:0]        mem_lanes;

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = {b_ff, g_ff, r_ff};
      mem_lanes = lane_en;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_addr  = clr_cnt_ff;
         mem_wdata = '0;
         mem_lanes = 3'b111;
      end else if (cmd.fetch) begin
         mem_re   = 1'b1;
         mem_addr = corner_addr;
      end else if (cmd.access) begin
         mem_we = op_ff == OP_WRITE;
         mem_re = op_ff == OP_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (mem_lanes[0]) mem[mem_addr][7:0]   <= mem_wdata[7:0];
         if (mem_lanes[1]) mem[mem_addr][15:8]  <= mem_wdata[15:8];
         if (mem_lanes[2]) mem[mem_addr][23:16] <= mem_wdata[23:16];
      end
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

   logic [7:0] byte_r, byte_g, byte_b;
   assign byte_r = rdata_ff[7:0];
   assign byte_g = lane_en[1] ? rdata_ff[15:8]  : 8'd0;
   assign byte_b = lane_en[2] ? rdata_ff[23:16] : 8'd0;

   // weighted accumulation, one corner behind the fetch
   logic             acc_pend_ff;
   logic [WGT_W-1:0] wgt_ff;
   logic [ACC_W-1:0] acc_r_ff, acc_g_ff, acc_b_ff;

   always_ff @(posedge clock) begin
      if (reset) acc_pend_ff <= 1'b0;
      else acc_pend_ff <= cmd.fetch;
      if (cmd.fetch) wgt_ff <= WGT_W'(wu) * WGT_W'(wv);
      if (cmd.setup) begin
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
      end else if (acc_pend_ff) begin
         acc_r_ff <= acc_r_ff + ACC_W'(byte_r) * ACC_W'(wgt_ff);
         acc_g_ff <= acc_g_ff + ACC_W'(byte_g) * ACC_W'(wgt_ff);
         acc_b_ff <= acc_b_ff + ACC_W'(byte_b) * ACC_W'(wgt_ff);
      end
   end

   function automatic logic [15:0] scale(input logic [ACC_W-1:0] s);
      logic [ACC_W:0] t;
      t = (ACC_W+1)'(s) + (ACC_W+1)'(1 << (ROUND_SH - 1));
      return 16'(t >> ROUND_SH);
   endfunction

   // result register
   logic        rsp_valid_ff;
   logic [15:0] ro_ff, go_ff, bo_ff;
   logic        st_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.finish) begin
         st_ff <= bad_ff;
         ro_ff <= '0;
         go_ff <= '0;
         bo_ff <= '0;
         if (!bad_ff && op_ff == OP_READ) begin
            ro_ff <= {byte_r, 8'd0};
            go_ff <= {byte_g, 8'd0};
            bo_ff <= {byte_b, 8'd0};
         end else if (!bad_ff && op_ff == OP_SAMPLE) begin
            ro_ff <= scale(acc_r_ff);
            go_ff <= scale(acc_g_ff);
            bo_ff <= scale(acc_b_ff);
         end
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign red_out       = ro_ff;
   assign green_out     = go_ff;
   assign blue_out      = bo_ff;
   assign status        = st_ff;

endmodule

FILE: rtl/mip_texture_store_bilinear_sampler_top.sv
// Top level of the mip texel store and bilinear sampler.
// Depends on mtbs_pkg, mtbs_ctrl and mtbs_dpath.
//
//   channel  dir  ports                          word
//   req      in   req_tvalid/tready/tdata/tuser  one access (write, read, sample)
//   rsp      out  rsp_tvalid/tready/tdata/tuser  one result per access
//   csr      in   csr_valid/ready/index/data     register write, idle or clearing only
//
// A write or read goes through setup and access before its result is loaded; a sample
// goes through setup, four corner fetches, one per cycle from the single-port texel
// memory, and a drain; a rejected access goes from setup to its result. The next access
// is taken once the result is loaded. After reset and after every register write a
// clearing pass zeroes all 87381 texel memory entries; no access is accepted meanwhile.
// A finished result waits in the output register; the next access is accepted
// while it waits, and the block holds only when that result is still not taken.
module mip_texture_store_bilinear_sampler_top
   import mtbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // level[3:0], texel_x[11:4], texel_y[19:12], red_in[27:20], green_in[35:28],
   // blue_in[43:36], coord_u[59:44], coord_v[75:60], zero fill
   input  logic [79:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red_out[15:0], green_out[31:16], blue_out[47:32]
   output logic [47:0] rsp_tdata,
   // status[0]
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_fire, csr_fire;

   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_tvalid && req_tready;

   mtbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .csr_fire  (csr_fire),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_tready),
      .csr_ready (csr_ready)
   );

   mtbs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .operation (req_tuser),
      .level     (req_tdata[3:0]),
      .texel_x   (req_tdata[11:4]),
      .texel_y   (req_tdata[19:12]),
      .red_in    (req_tdata[27:20]),
      .green_in  (req_tdata[35:28]),
      .blue_in   (req_tdata[43:36]),
      .coord_u   (req_tdata[59:44]),
      .coord_v   (req_tdata[75:60]),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .red_out   (rsp_tdata[15:0]),
      .green_out (rsp_tdata[31:16]),
      .blue_out  (rsp_tdata[47:32]),
      .status    (rsp_tuser)
   );

endmodule

FILE: verif/tb_mip_texture_store_bilinear_sampler_top.sv
// Self-checking testbench for the mip texel store and bilinear sampler.
// Drives random and directed accesses under several register settings and checks
// every result against an in-bench predictor; depends on mtbs_pkg and the top level.
module tb_mip_texture_store_bilinear_sampler_top;
   import mtbs_pkg::*;

   localparam int         STORE_SIZE = TEX_DEPTH + MAX_LEVELS;
   localparam longint     CYCLE_LIMIT = 5_000_000;

   typedef struct {
      logic [1:0]  op;
      logic [3:0]  level;
      logic [7:0]  tx, ty, red, green, blue;
      logic [15:0] u, v;
   } access_t;

   typedef struct {
      logic [15:0] red, green, blue;
      logic        status;
   } texel_result_t;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;

   access_t       access_queue[$];
   texel_result_t results_due[$];
   access_t       next_access;
   logic          req_taken;
   logic          hold_rsp;
   int            send_idle_pct, recv_idle_pct;
   int            mismatches;
   int            accepted_words;
   longint        cycles = 0;

   // predictor state
   logic [23:0]   texels [0:STORE_SIZE-1];
   int unsigned   lvl_off [0:MAX_LEVELS-1];
   int unsigned   lvl_w [0:MAX_LEVELS-1];
   int unsigned   lvl_h [0:MAX_LEVELS-1];
   int unsigned   cfg_w, cfg_h, cfg_levels, cfg_fmt;

   mip_texture_store_bilinear_sampler_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int unsigned clamp_range(input int unsigned x, lo, hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic int unsigned levels_in_use();
      return clamp_range(cfg_levels, 1, MAX_LEVELS);
   endfunction

   function automatic logic [23:0] format_mask();
      case (cfg_fmt)
         FMT_R8:   return 24'h0000FF;
         FMT_RG88: return 24'h00FFFF;
         default:  return 24'hFFFFFF;
      endcase
   endfunction

   function void rebuild_layout();
      int unsigned w, h, off;
      w = clamp_range(cfg_w, 1, MAX_DIM);
      h = clamp_range(cfg_h, 1, MAX_DIM);
      off = 0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         lvl_off[k] = off;
         lvl_w[k] = w;
         lvl_h[k] = h;
         off += w * h;
         w = (w > 1) ? w >> 1 : 1;
         h = (h > 1) ? h >> 1 : 1;
      end
      for (int a = 0; a < STORE_SIZE; a++) texels[a] = '0;
   endfunction

   function void apply_register(input logic [1:0] index, input logic [8:0] value);
      case (index)
         REG_BASE_WIDTH:   cfg_w = value;
         REG_BASE_HEIGHT:  cfg_h = value;
         REG_LEVEL_COUNT:  cfg_levels = value[3:0];
         REG_TEXEL_FORMAT: cfg_fmt = value[1:0];
         default: ;
      endcase
      rebuild_layout();
   endfunction

   function automatic int unsigned axis_weight(input int unsigned coord, size,
                                               output int unsigned i0, i1);
      longint unsigned q;
      int unsigned top;
      q = longint'(coord) * size + 32768;
      top = q >> 16;
      i0 = (top == 0) ? size - 1 : top - 1;
      i1 = (top >= size) ? 0 : top;
      return (q & 16'hFFFF) >> (16 - WEIGHT_BITS);
   endfunction

   function automatic logic [23:0] corner(input int unsigned lv, x, y);
      return texels[lvl_off[lv] + y * lvl_w[lv] + x] & format_mask();
   endfunction

   function texel_result_t model_access(input access_t a);
      texel_result_t r;
      int unsigned addr, x0, x1, y0, y1, fu, fv;
      longint unsigned w00, w10, w01, w11, acc;
      logic [23:0] c00, c10, c01, c11, t;
      r = '{red: 0, green: 0, blue: 0, status: 1'b1};
      if (a.op == OP_NONE || a.level >= levels_in_use()) return r;
      if (a.op == OP_WRITE || a.op == OP_READ) begin
         if (a.tx >= lvl_w[a.level] || a.ty >= lvl_h[a.level]) return r;
         addr = lvl_off[a.level] + a.ty * lvl_w[a.level] + a.tx;
         if (a.op == OP_WRITE) begin
            t = {a.blue, a.green, a.red};
            texels[addr] = (texels[addr] & ~format_mask()) | (t & format_mask());
         end else begin
            t = texels[addr] & format_mask();
            r.red = {t[7:0], 8'h00};
            r.green = {t[15:8], 8'h00};
            r.blue = {t[23:16], 8'h00};
         end
         r.status = 1'b0;
         return r;
      end
      fu = axis_weight(a.u, lvl_w[a.level], x0, x1);
      fv = axis_weight(a.v, lvl_h[a.level], y0, y1);
      c00 = corner(a.level, x0, y0);
      c10 = corner(a.level, x1, y0);
      c01 = corner(a.level, x0, y1);
      c11 = corner(a.level, x1, y1);
      w00 = (256 - fu) * (256 - fv);
      w10 = fu * (256 - fv);
      w01 = (256 - fu) * fv;
      w11 = fu * fv;
      for (int ch = 0; ch < 3; ch++) begin
         acc = c00[8*ch +: 8] * w00 + c10[8*ch +: 8] * w10 +
               c01[8*ch +: 8] * w01 + c11[8*ch +: 8] * w11;
         acc = (acc + (1 << (ROUND_SH - 1))) >> ROUND_SH;
         case (ch)
            0: r.red = acc[15:0];
            1: r.green = acc[15:0];
            default: r.blue = acc[15:0];
         endcase
      end
      r.status = 1'b0;
      return r;
   endfunction

   function automatic access_t random_access();
      access_t a;
      int unsigned pick, lv;
      pick = $urandom_range(99);
      a.op = pick < 32 ? OP_WRITE : (pick < 57 ? OP_READ : (pick < 95 ? OP_SAMPLE : OP_NONE));
      a.level = ($urandom_range(99) < 88) ? 4'($urandom_range(levels_in_use() - 1))
                                          : 4'($urandom_range(15));
      lv = (a.level < MAX_LEVELS) ? a.level : 0;
      if ($urandom_range(99) < 85) begin
         a.tx = 8'($urandom_range(lvl_w[lv] - 1));
         a.ty = 8'($urandom_range(lvl_h[lv] - 1));
      end else begin
         a.tx = 8'($urandom_range(255));
         a.ty = 8'($urandom_range(255));
      end
      a.red = 8'($urandom);
      a.green = 8'($urandom);
      a.blue = 8'($urandom);
      a.u = 16'($urandom);
      a.v = 16'($urandom);
      if ($urandom_range(9) == 0) a.u = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(9) == 0) a.v = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      return a;
   endfunction

   task automatic push_access(input logic [1:0] op, input logic [3:0] level,
                              input logic [7:0] tx, ty, red, green, blue,
                              input logic [15:0] u, v);
      access_queue.push_back('{op: op, level: level, tx: tx, ty: ty, red: red,
                               green: green, blue: blue, u: u, v: v});
   endtask

   task automatic report_mismatch(input string what, input int unsigned want, got);
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
      mismatches++;
   endtask

   task automatic wait_idle();
      while (access_queue.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      apply_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int n);
      for (int k = 0; k < n; k++) access_queue.push_back(random_access());
      wait_idle();
   endtask

   // driver: offer the next word at the falling edge
   always @(posedge clock) req_taken <= req_tvalid && req_tready;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_access = access_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_access.op;
            req_tdata  <= {4'h0, next_access.v, next_access.u, next_access.blue,
                           next_access.green, next_access.red, next_access.ty,
                           next_access.tx, next_access.level};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         results_due.push_back(model_access('{op: req_tuser, level: req_tdata[3:0],
            tx: req_tdata[11:4], ty: req_tdata[19:12], red: req_tdata[27:20],
            green: req_tdata[35:28], blue: req_tdata[43:36], u: req_tdata[59:44],
            v: req_tdata[75:60]}));
         accepted_words++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected word", 0, rsp_tdata[15:0]);
         end else begin
            if (rsp_tdata[15:0] != results_due[0].red)
               report_mismatch("red_out", results_due[0].red, rsp_tdata[15:0]);
            if (rsp_tdata[31:16] != results_due[0].green)
               report_mismatch("green_out", results_due[0].green, rsp_tdata[31:16]);
            if (rsp_tdata[47:32] != results_due[0].blue)
               report_mismatch("blue_out", results_due[0].blue, rsp_tdata[47:32]);
            if (rsp_tuser != results_due[0].status)
               report_mismatch("status", results_due[0].status, rsp_tuser);
            void'(results_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      hold_rsp = 1'b0;
      wait (accepted_words >= 60);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (500) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_taken = 1'b0;
      mismatches = 0;
      accepted_words = 0;
      send_idle_pct = 16;
      recv_idle_pct = 45;
      cfg_w = 256;
      cfg_h = 256;
      cfg_levels = 1;
      cfg_fmt = FMT_RGB888;
      rebuild_layout();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, wrap, missing levels, unknown operation
      push_access(OP_WRITE, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0);
      push_access(OP_WRITE, 0, 255, 255, 8'h12, 8'h34, 8'h56, 0, 0);
      push_access(OP_WRITE, 0, 255, 0, 8'hA5, 8'h5A, 8'h0F, 0, 0);
      push_access(OP_WRITE, 0, 0, 255, 8'h80, 8'h01, 8'hF0, 0, 0);
      push_access(OP_WRITE, 0, 1, 1, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
      push_access(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      push_access(OP_READ, 0, 255, 255, 0, 0, 0, 0, 0);
      push_access(OP_READ, 0, 255, 0, 0, 0, 0, 0, 0);
      push_access(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000);
      push_access(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
      push_access(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF);
      push_access(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0080, 16'h00C0);
      push_access(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h8000);
      push_access(OP_WRITE, 1, 0, 0, 8'h11, 8'h22, 8'h33, 0, 0);
      push_access(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
      push_access(OP_SAMPLE, 15, 0, 0, 0, 0, 0, 16'h4000, 16'h4000);
      push_access(OP_WRITE, 15, 255, 255, 8'hFF, 8'hFF, 8'hFF, 0, 0);
      push_access(OP_NONE, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      push_access(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      wait_idle();

      write_register(REG_LEVEL_COUNT, 9'd15);
      run_random(400);

      send_idle_pct = 45;
      recv_idle_pct = 16;
      write_register(REG_TEXEL_FORMAT, 9'(FMT_R8));
      write_register(REG_BASE_WIDTH, 9'd5);
      run_random(300);

      write_register(REG_BASE_HEIGHT, 9'd0);
      write_register(REG_TEXEL_FORMAT, 9'(FMT_RG88));
      run_random(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_BASE_WIDTH, 9'd511);
      write_register(REG_LEVEL_COUNT, 9'd0);
      write_register(REG_TEXEL_FORMAT, 9'd3);
      run_random(330);

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mtbs_pkg.sv
rtl/mtbs_ctrl.sv
rtl/mtbs_dpath.sv
rtl/mip_texture_store_bilinear_sampler_top.sv
verif/tb_mip_texture_store_bilinear_sampler_top.sv
